/* design/network_traffic_generator_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the network traffic generator core
// Shared concurrent-assertion forms, sampled on clk and muted during reset.
// ----------------------------------------------------------------------------
`ifndef NETWORK_TRAFFIC_GENERATOR_CORE_DEFINES_SVH
`define NETWORK_TRAFFIC_GENERATOR_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define NTG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause
`define NTG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ntg_pkg.sv */
// ----------------------------------------------------------------------------
// ntg_pkg
// Types, constants and codes shared by the traffic generator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ntg_pkg;

	// Sizing
	localparam int MAX_VALUES      = 19;
	localparam int ROUTER_COUNTERS = 16;
	localparam int NUM_CAND        = ROUTER_COUNTERS + 3;
	localparam int SLOT_W          = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
	localparam int RIDX_W          = (ROUTER_COUNTERS > 1) ? $clog2(ROUTER_COUNTERS) : 1;

	// Command queue and result queue
	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW    = $clog2(CQ_DEPTH);
	localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	// Fixed values
	localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;
	localparam logic [31:0] PAYLOAD_PATTERN = 32'hDEAD_BEEF;

	// Record mask positions of the local totals
	localparam int BIT_SENT    = 16;
	localparam int BIT_BLOCKED = 17;
	localparam int BIT_ARRIVED = 24;

	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_ARRIVED    = 3'd1,
		OP_CNT_UPDATE = 3'd2,
		OP_START_RUN  = 3'd3,
		OP_END_RUN    = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		REG_RECORD_MASK       = 3'd0,
		REG_RECORD_INTERVAL   = 3'd1,
		REG_SEND_PROBABILITY  = 3'd2,
		REG_BURST_PERIOD      = 3'd3,
		REG_BURST_DUTY        = 3'd4,
		REG_BURST_PHASE_START = 3'd5,
		REG_PACKET_KEY        = 3'd6,
		REG_PAYLOAD_ENABLE    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] random_word;
		logic        network_ready;
		logic [3:0]  counter_index;
		logic [31:0] counter_value;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] out_key;
		logic        has_payload;
		logic [31:0] payload_word;
		logic [31:0] delta_value;
		logic        last_of_run;
	} out_item_t;

	// Classified request handed from the front to the back
	typedef struct packed {
		opcode_t     opcode;
		logic        send_ok;
		logic        ready;
		logic [3:0]  counter_index;
		logic [31:0] counter_value;
	} cmd_t;

	typedef struct packed {
		logic [31:0] record_mask;
		logic [30:0] record_interval;
		logic [31:0] send_probability;
		logic [31:0] burst_period;
		logic [31:0] burst_duty;
		logic [31:0] packet_key;
		logic        payload_enable;
	} cfg_t;

endpackage

`default_nettype wire

/* design/network_traffic_generator_core.sv */
// ----------------------------------------------------------------------------
// network_traffic_generator_core
// Tick-driven packet generator with interval recording of counter deltas.
// ----------------------------------------------------------------------------
// Requests enter through a one-entry front stage and a four-entry queue, so
// push keeps flowing while the back is busy or results wait to be popped.
// The back executes one request at a time: it fetches a tick, arrival,
// counter update or run boundary from the queue, then executes it. A
// recording, and the silent sampling at start of run, then walks the
// selected counters (at most 19) one per cycle, stalling only while a
// delta to be emitted finds the result queue full.
// Results pass through a four-entry queue; a full result queue stalls the
// back, never the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module network_traffic_generator_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  ntg_pkg::in_item_t  command,
	output logic               empty,
	input  wire logic          pop,
	output ntg_pkg::out_item_t result,
	input  wire logic          cfg_write,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [31:0]   cfg_data
);

	ntg_pkg::cfg_t  cfg_q;
	logic           phase_load;
	logic           cq_push;
	ntg_pkg::cmd_t  cq_wr_item;
	logic           cq_full;
	logic           cq_pop;
	ntg_pkg::cmd_t  cq_rd_item;
	logic           cq_empty;

	assign phase_load = cfg_write &&
		(ntg_pkg::cfg_reg_t'(cfg_index) == ntg_pkg::REG_BURST_PHASE_START);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ntg_pkg::cfg_t'{
				record_mask:      32'd0,
				record_interval:  31'd0,
				send_probability: ntg_pkg::ALL_ONES,
				burst_period:     32'd0,
				burst_duty:       32'd0,
				packet_key:       32'd0,
				payload_enable:   1'b0
			};
		end else if (cfg_write) begin
			case (ntg_pkg::cfg_reg_t'(cfg_index))
				ntg_pkg::REG_RECORD_MASK:      cfg_q.record_mask      <= cfg_data;
				ntg_pkg::REG_RECORD_INTERVAL:  cfg_q.record_interval  <= cfg_data[30:0];
				ntg_pkg::REG_SEND_PROBABILITY: cfg_q.send_probability <= cfg_data;
				ntg_pkg::REG_BURST_PERIOD:     cfg_q.burst_period     <= cfg_data;
				ntg_pkg::REG_BURST_DUTY:       cfg_q.burst_duty       <= cfg_data;
				ntg_pkg::REG_PACKET_KEY:       cfg_q.packet_key       <= cfg_data;
				ntg_pkg::REG_PAYLOAD_ENABLE:   cfg_q.payload_enable   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	ntg_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.command          (command),
		.send_probability (cfg_q.send_probability),
		.cq_push          (cq_push),
		.cq_item          (cq_wr_item),
		.cq_full          (cq_full)
	);

	ntg_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cq_push),
		.wr_item (cq_wr_item),
		.q_full  (cq_full),
		.rd_en   (cq_pop),
		.rd_item (cq_rd_item),
		.q_empty (cq_empty)
	);

	ntg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.phase_load  (phase_load),
		.phase_value (cfg_data),
		.cq_item     (cq_rd_item),
		.cq_empty    (cq_empty),
		.cq_pop      (cq_pop),
		.empty       (empty),
		.pop         (pop),
		.result      (result)
	);

endmodule

`default_nettype wire

/* design/ntg_front.sv */
// ----------------------------------------------------------------------------
// ntg_front
// Accepts requests, drops ones with no effect, and evaluates the send chance.
// ----------------------------------------------------------------------------
`default_nettype none

module ntg_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  ntg_pkg::in_item_t     command,
	input  wire logic [31:0]      send_probability,
	output logic                  cq_push,
	output ntg_pkg::cmd_t         cq_item,
	input  wire logic             cq_full
);

	logic           valid_s1;
	ntg_pkg::cmd_t  cmd_s1;
	logic           accept;
	logic           keep;
	logic           idx_ok;
	ntg_pkg::cmd_t  cmd_new;

	// Classify the incoming request
	always_comb begin
		idx_ok = 5'(command.counter_index) < 5'(ntg_pkg::ROUTER_COUNTERS);
		case (ntg_pkg::opcode_t'(command.opcode))
			ntg_pkg::OP_TICK,
			ntg_pkg::OP_ARRIVED,
			ntg_pkg::OP_START_RUN,
			ntg_pkg::OP_END_RUN:   keep = 1'b1;
			ntg_pkg::OP_CNT_UPDATE: keep = idx_ok;
			default:               keep = 1'b0;
		endcase
		cmd_new.opcode        = ntg_pkg::opcode_t'(command.opcode);
		cmd_new.send_ok       = (send_probability == ntg_pkg::ALL_ONES) ||
		                        (command.random_word < send_probability);
		cmd_new.ready         = command.network_ready;
		cmd_new.counter_index = command.counter_index;
		cmd_new.counter_value = command.counter_value;
	end

	assign full    = valid_s1 & cq_full;
	assign accept  = push & ~full;
	assign cq_push = valid_s1 & ~cq_full;
	assign cq_item = cmd_s1;

	// Hold one classified request until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (cq_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_new;
		end
	end

endmodule

`default_nettype wire

/* design/ntg_cmdq.sv */
// ----------------------------------------------------------------------------
// ntg_cmdq
// Short request queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ntg_cmdq (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_en,
	input  ntg_pkg::cmd_t  wr_item,
	output logic           q_full,
	input  wire logic      rd_en,
	output ntg_pkg::cmd_t  rd_item,
	output logic           q_empty
);

	ntg_pkg::cmd_t                 mem_q [ntg_pkg::CQ_DEPTH];
	logic [ntg_pkg::CQ_AW-1:0]     wr_ptr_q;
	logic [ntg_pkg::CQ_AW-1:0]     rd_ptr_q;
	logic [ntg_pkg::CQ_CW-1:0]     count_q;
	logic                          do_wr;
	logic                          do_rd;

	assign q_full  = (count_q == ntg_pkg::CQ_CW'(ntg_pkg::CQ_DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en & ~q_full;
	assign do_rd   = rd_en & ~q_empty;
	assign rd_item = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ntg_pkg::CQ_AW'(wr_ptr_q + 1'b1);
			end
			if (do_rd) begin
				rd_ptr_q <= ntg_pkg::CQ_AW'(rd_ptr_q + 1'b1);
			end
			if (do_wr && !do_rd) begin
				count_q <= ntg_pkg::CQ_CW'(count_q + 1'b1);
			end else if (do_rd && !do_wr) begin
				count_q <= ntg_pkg::CQ_CW'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

/* design/ntg_back.sv */
// ----------------------------------------------------------------------------
// ntg_back
// Executes requests: send decision, counters, and the recording walk that
// emits one counter delta per cycle, while there is room, into a small result queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "network_traffic_generator_core_defines.svh"

module ntg_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  ntg_pkg::cfg_t      cfg,
	input  wire logic          phase_load,
	input  wire logic [31:0]   phase_value,
	input  ntg_pkg::cmd_t      cq_item,
	input  wire logic          cq_empty,
	output logic               cq_pop,
	output logic               empty,
	input  wire logic          pop,
	output ntg_pkg::out_item_t result
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_WALK = 3'b100
	} state_t;

	state_t                          state_q;
	ntg_pkg::cmd_t                   cur_q;
	logic [31:0]                     burst_phase_q;
	logic [31:0]                     interval_q;
	logic [31:0]                     sent_q;
	logic [31:0]                     blocked_q;
	logic [31:0]                     arrived_q;
	logic [31:0]                     shadow_q [ntg_pkg::ROUTER_COUNTERS];
	logic [31:0]                     prev_q [ntg_pkg::MAX_VALUES];
	logic [ntg_pkg::NUM_CAND-1:0]    pending_q;
	logic [ntg_pkg::SLOT_W-1:0]      slot_q;
	logic                            emit_q;

	ntg_pkg::out_item_t              oq_mem_q [ntg_pkg::OQ_DEPTH];
	logic [ntg_pkg::OQ_AW-1:0]       oq_wr_q;
	logic [ntg_pkg::OQ_AW-1:0]       oq_rd_q;
	logic [ntg_pkg::OQ_CW-1:0]       oq_cnt_q;

	logic [ntg_pkg::NUM_CAND-1:0]    sel;
	logic [31:0]                     cand_val [ntg_pkg::NUM_CAND];
	logic [ntg_pkg::NUM_CAND-1:0]    low1;
	logic [ntg_pkg::NUM_CAND-1:0]    pending_nxt;
	logic [31:0]                     walk_val;
	logic                            walk_done;

	logic                            burst_on;
	logic                            allowed;
	logic [31:0]                     phase_inc;
	logic [31:0]                     phase_nxt;
	logic                            fire;
	logic                            pkt;
	logic                            interval_on;
	logic [31:0]                     ic_inc;
	logic                            rec_now;
	logic                            is_tick;

	logic                            oq_full;
	logic                            oq_pop;
	logic                            oq_push;
	ntg_pkg::out_item_t              push_item;
	logic                            do_exec;
	logic                            do_walk;

	// Candidate counters in mask order: router counters, sent, blocked, arrived
	always_comb begin
		sel = {cfg.record_mask[ntg_pkg::BIT_ARRIVED], cfg.record_mask[ntg_pkg::BIT_BLOCKED],
		       cfg.record_mask[ntg_pkg::BIT_SENT],
		       cfg.record_mask[ntg_pkg::ROUTER_COUNTERS-1:0]};
		for (int i = 0; i < ntg_pkg::ROUTER_COUNTERS; i++) begin
			cand_val[i] = shadow_q[i];
		end
		cand_val[ntg_pkg::ROUTER_COUNTERS]     = sent_q;
		cand_val[ntg_pkg::ROUTER_COUNTERS + 1] = blocked_q;
		cand_val[ntg_pkg::ROUTER_COUNTERS + 2] = arrived_q;
	end

	// Pick the lowest pending counter and flag the end of the recording
	always_comb begin
		low1        = pending_q & ntg_pkg::NUM_CAND'(~pending_q + 1'b1);
		pending_nxt = pending_q & ~low1;
		walk_val    = '0;
		for (int i = 0; i < ntg_pkg::NUM_CAND; i++) begin
			if (low1[i]) begin
				walk_val = walk_val | cand_val[i];
			end
		end
		walk_done = (pending_nxt == '0) ||
		            (slot_q == ntg_pkg::SLOT_W'(ntg_pkg::MAX_VALUES - 1));
	end

	// Tick decision: burst window, send chance, recording interval
	always_comb begin
		burst_on    = (cfg.burst_period != '0);
		allowed     = !burst_on || (burst_phase_q < cfg.burst_duty);
		phase_inc   = burst_phase_q + 32'd1;
		phase_nxt   = burst_phase_q;
		if (burst_on) begin
			phase_nxt = (phase_inc >= cfg.burst_period) ? 32'd0 : phase_inc;
		end
		fire        = allowed & cur_q.send_ok;
		pkt         = fire & cur_q.ready;
		interval_on = (cfg.record_interval != '0);
		ic_inc      = interval_q + 32'd1;
		rec_now     = interval_on && (ic_inc >= {1'b0, cfg.record_interval});
		is_tick     = (cur_q.opcode == ntg_pkg::OP_TICK);
	end

	// Result queue handshake and the stall conditions of the back
	assign oq_full = (oq_cnt_q == ntg_pkg::OQ_CW'(ntg_pkg::OQ_DEPTH));
	assign empty   = (oq_cnt_q == '0);
	assign oq_pop  = pop & ~empty;
	assign result  = oq_mem_q[oq_rd_q];
	assign cq_pop  = (state_q == S_IDLE) & ~cq_empty;
	assign do_exec = (state_q == S_EXEC) & ~(is_tick & pkt & oq_full);
	assign do_walk = (state_q == S_WALK) & (pending_q != '0) & ~(emit_q & oq_full);
	assign oq_push = (do_exec & is_tick & pkt) | (do_walk & emit_q);

	always_comb begin
		push_item = '0;
		if (state_q == S_WALK) begin
			push_item.kind        = 1'b1;
			push_item.delta_value = walk_val - prev_q[slot_q];
			push_item.last_of_run = walk_done;
		end else begin
			push_item.kind         = 1'b0;
			push_item.out_key      = cfg.packet_key;
			push_item.has_payload  = cfg.payload_enable;
			push_item.payload_word = cfg.payload_enable ? ntg_pkg::PAYLOAD_PATTERN : 32'd0;
		end
	end

	// Sequence requests and update the counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			burst_phase_q <= '0;
			interval_q    <= '0;
			sent_q        <= '0;
			blocked_q     <= '0;
			arrived_q     <= '0;
			pending_q     <= '0;
			slot_q        <= '0;
			emit_q        <= 1'b0;
			for (int i = 0; i < ntg_pkg::ROUTER_COUNTERS; i++) begin
				shadow_q[i] <= '0;
			end
			for (int i = 0; i < ntg_pkg::MAX_VALUES; i++) begin
				prev_q[i] <= '0;
			end
		end else begin
			if (phase_load) begin
				burst_phase_q <= phase_value;
			end
			case (state_q)
				S_IDLE: begin
					if (cq_pop) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (do_exec) begin
						state_q   <= S_IDLE;
						pending_q <= sel;
						slot_q    <= '0;
						case (cur_q.opcode)
							ntg_pkg::OP_TICK: begin
								burst_phase_q <= phase_nxt;
								if (fire && cur_q.ready) begin
									sent_q <= sent_q + 32'd1;
								end else if (fire) begin
									blocked_q <= blocked_q + 32'd1;
								end
								if (interval_on) begin
									interval_q <= rec_now ? 32'd0 : ic_inc;
								end
								if (rec_now) begin
									emit_q  <= 1'b1;
									state_q <= S_WALK;
								end
							end
							ntg_pkg::OP_ARRIVED: begin
								arrived_q <= arrived_q + 32'd1;
							end
							ntg_pkg::OP_CNT_UPDATE: begin
								shadow_q[cur_q.counter_index[ntg_pkg::RIDX_W-1:0]] <=
									cur_q.counter_value;
							end
							ntg_pkg::OP_START_RUN: begin
								interval_q <= '0;
								emit_q     <= 1'b0;
								state_q    <= S_WALK;
							end
							ntg_pkg::OP_END_RUN: begin
								if (!interval_on) begin
									emit_q  <= 1'b1;
									state_q <= S_WALK;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_WALK: begin
					if (pending_q == '0) begin
						state_q <= S_IDLE;
					end else if (do_walk) begin
						prev_q[slot_q] <= walk_val;
						slot_q         <= ntg_pkg::SLOT_W'(slot_q + 1'b1);
						pending_q      <= pending_nxt;
						if (walk_done) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the request being executed
	always_ff @(posedge clk) begin
		if (cq_pop) begin
			cur_q <= cq_item;
		end
	end

	// Result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= ntg_pkg::OQ_AW'(oq_wr_q + 1'b1);
			end
			if (oq_pop) begin
				oq_rd_q <= ntg_pkg::OQ_AW'(oq_rd_q + 1'b1);
			end
			if (oq_push && !oq_pop) begin
				oq_cnt_q <= ntg_pkg::OQ_CW'(oq_cnt_q + 1'b1);
			end else if (oq_pop && !oq_push) begin
				oq_cnt_q <= ntg_pkg::OQ_CW'(oq_cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_mem_q[oq_wr_q] <= push_item;
		end
	end

	`NTG_ASSERT_SAME(a_oq_room, oq_push, !oq_full, "result pushed into a full queue")
	`NTG_ASSERT_SAME(a_slot_range, state_q == S_WALK,
		slot_q <= ntg_pkg::SLOT_W'(ntg_pkg::MAX_VALUES - 1), "sample slot out of range")
	`NTG_ASSERT_NEXT(a_last_ends, oq_push && push_item.kind && push_item.last_of_run,
		state_q == S_IDLE, "walk continued after the last delta")

endmodule

`default_nettype wire

/* test/tb_network_traffic_generator_core.sv */
// ----------------------------------------------------------------------------
// tb_network_traffic_generator_core
// Self-checking bench for the traffic generator core: a directed table walks
// reset values, register extremes, the send decision, bursting, run starts
// and ends and spare opcodes; random runs follow under bursty requests and a
// stalling result side. Every result is compared field by field against an
// in-bench prediction of packets and counter deltas.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_network_traffic_generator_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD    = 10;
	localparam int IDLE_SETTLE   = 6 * (2 + ntg_pkg::MAX_VALUES) + 20;
	localparam int QUIET_LIMIT   = 4000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 42;

	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_CHECKED,
		ROW_TYPED
	} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		ntg_pkg::cfg_reg_t  sel;
		logic [31:0]        data;
		ntg_pkg::in_item_t  cmd;
		ntg_pkg::out_item_t typed;
	} table_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	ntg_pkg::in_item_t  command = '0;
	logic               empty;
	logic               pop = 1'b0;
	ntg_pkg::out_item_t result;
	logic               cfg_write = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	network_traffic_generator_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.command  (command),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Predicted configuration and state of the generator
	logic [31:0] record_mask = '0;
	logic [30:0] record_interval = '0;
	logic [31:0] send_prob = ntg_pkg::ALL_ONES;
	logic [31:0] burst_period = '0;
	logic [31:0] burst_duty = '0;
	logic [31:0] packet_key = '0;
	logic        payload_en = 1'b0;
	logic [31:0] burst_phase = '0;
	logic [31:0] interval_count = '0;
	logic [31:0] sent_total = '0;
	logic [31:0] blocked_total = '0;
	logic [31:0] arrived_total = '0;
	logic [31:0] router_shadow [ntg_pkg::ROUTER_COUNTERS];
	logic [31:0] prev_sample [ntg_pkg::MAX_VALUES];

	ntg_pkg::out_item_t step_traffic [$];
	ntg_pkg::out_item_t traffic_due [$];
	table_row_t         directed_rows [$];

	int                 burst_left = 0;
	int                 requests_sent = 0;
	int                 spare_ops = 0;
	int                 results_seen = 0;
	int                 packets_seen = 0;
	int                 recordings_seen = 0;
	int                 reg_writes = 0;
	int                 mismatches = 0;
	int                 quiet_cycles = 0;
	logic [8:0]         stall_step = '0;
	ntg_pkg::out_item_t oldest;

	initial begin
		foreach (router_shadow[i]) router_shadow[i] = '0;
		foreach (prev_sample[i]) prev_sample[i] = '0;
	end

	function automatic ntg_pkg::in_item_t mk_cmd(logic [2:0] op, logic [31:0] rnd,
			logic rdy, logic [3:0] idx, logic [31:0] val);
		ntg_pkg::in_item_t c;
		c.opcode        = op;
		c.random_word   = rnd;
		c.network_ready = rdy;
		c.counter_index = idx;
		c.counter_value = val;
		return c;
	endfunction

	function automatic ntg_pkg::out_item_t packet_of(logic [31:0] key, logic hp);
		ntg_pkg::out_item_t o;
		o              = '0;
		o.kind         = 1'b0;
		o.out_key      = key;
		o.has_payload  = hp;
		o.payload_word = hp ? ntg_pkg::PAYLOAD_PATTERN : 32'h0;
		return o;
	endfunction

	function automatic table_row_t row_write(ntg_pkg::cfg_reg_t sel, logic [31:0] data);
		table_row_t r;
		r.kind  = ROW_WRITE;
		r.sel   = sel;
		r.data  = data;
		r.cmd   = '0;
		r.typed = '0;
		return r;
	endfunction

	function automatic table_row_t row_req(ntg_pkg::in_item_t c);
		table_row_t r;
		r.kind  = ROW_CHECKED;
		r.sel   = ntg_pkg::REG_RECORD_MASK;
		r.data  = '0;
		r.cmd   = c;
		r.typed = '0;
		return r;
	endfunction

	function automatic table_row_t row_typed(ntg_pkg::in_item_t c, ntg_pkg::out_item_t o);
		table_row_t r;
		r       = row_req(c);
		r.kind  = ROW_TYPED;
		r.typed = o;
		return r;
	endfunction

	// Walk the selected counters in mask order, optionally emitting deltas
	task automatic snapshot_counters(input bit emit);
		int                 slot;
		int                 first;
		bit                 have;
		logic [31:0]        v;
		ntg_pkg::out_item_t d;
		slot  = 0;
		first = step_traffic.size();
		for (int b = 0; b < 32; b++) begin
			if (!record_mask[b])
				continue;
			have = 1'b1;
			v    = '0;
			if (b < ntg_pkg::ROUTER_COUNTERS && b < 16)
				v = router_shadow[b];
			else if (b == ntg_pkg::BIT_SENT)
				v = sent_total;
			else if (b == ntg_pkg::BIT_BLOCKED)
				v = blocked_total;
			else if (b == ntg_pkg::BIT_ARRIVED)
				v = arrived_total;
			else
				have = 1'b0;
			if (!have)
				continue;
			if (slot >= ntg_pkg::MAX_VALUES)
				break;
			if (emit) begin
				d             = '0;
				d.kind        = 1'b1;
				d.delta_value = v - prev_sample[slot];
				step_traffic.push_back(d);
			end
			prev_sample[slot] = v;
			slot++;
		end
		if (emit && step_traffic.size() > first)
			step_traffic[step_traffic.size() - 1].last_of_run = 1'b1;
	endtask

	// Advance the predicted state by one request and collect its results
	task automatic predict_traffic(input ntg_pkg::in_item_t c);
		bit allowed;
		step_traffic.delete();
		case (c.opcode)
			ntg_pkg::OP_TICK: begin
				allowed = 1'b1;
				if (burst_period != 0) begin
					allowed = burst_phase < burst_duty;
					burst_phase++;
					if (burst_phase >= burst_period)
						burst_phase = '0;
				end
				if (allowed && (send_prob == ntg_pkg::ALL_ONES ||
						c.random_word < send_prob)) begin
					if (c.network_ready) begin
						sent_total++;
						step_traffic.push_back(packet_of(packet_key, payload_en));
					end else begin
						blocked_total++;
					end
				end
				if (record_interval != 0) begin
					interval_count++;
					if (interval_count >= record_interval) begin
						interval_count = '0;
						snapshot_counters(1'b1);
					end
				end
			end
			ntg_pkg::OP_ARRIVED: begin
				arrived_total++;
			end
			ntg_pkg::OP_CNT_UPDATE: begin
				if (c.counter_index < ntg_pkg::ROUTER_COUNTERS)
					router_shadow[c.counter_index] = c.counter_value;
			end
			ntg_pkg::OP_START_RUN: begin
				interval_count = '0;
				snapshot_counters(1'b0);
			end
			ntg_pkg::OP_END_RUN: begin
				if (record_interval == 0)
					snapshot_counters(1'b1);
			end
			default: begin
			end
		endcase
	endtask

	// Write one register at a falling edge and mirror it in the prediction
	task automatic write_reg(input ntg_pkg::cfg_reg_t sel, input logic [31:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		reg_writes++;
		case (sel)
			ntg_pkg::REG_RECORD_MASK:       record_mask = data;
			ntg_pkg::REG_RECORD_INTERVAL:   record_interval = data[30:0];
			ntg_pkg::REG_SEND_PROBABILITY:  send_prob = data;
			ntg_pkg::REG_BURST_PERIOD:      burst_period = data;
			ntg_pkg::REG_BURST_DUTY:        burst_duty = data;
			ntg_pkg::REG_BURST_PHASE_START: burst_phase = data;
			ntg_pkg::REG_PACKET_KEY:        packet_key = data;
			ntg_pkg::REG_PAYLOAD_ENABLE:    payload_en = data[0];
			default: begin
			end
		endcase
	endtask

	// Hold off requests until every predicted result has come, then settle
	task automatic wait_drained(input int settle);
		@(negedge clk);
		push <= 1'b0;
		burst_left = 0;
		while (traffic_due.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Push one request in bursts with random gaps, then predict its results
	task automatic send_request(input ntg_pkg::in_item_t c, input bit use_typed,
			input ntg_pkg::out_item_t typed);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				push <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		push    <= 1'b1;
		command <= c;
		do @(posedge clk); while (full !== 1'b0);
		if (c.opcode >= OP_SPARE_FIRST)
			spare_ops++;
		else
			requests_sent++;
		predict_traffic(c);
		if (use_typed)
			traffic_due.push_back(typed);
		else
			foreach (step_traffic[i]) traffic_due.push_back(step_traffic[i]);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t ns: %s expected %h, got %h", $time, name, want, got);
		end
	endtask

	// Receiver: cycle through steady, random, sparse and long-stall patterns
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			stall_step <= stall_step + 1'b1;
			case (stall_step[8:7])
				2'd0: pop <= 1'b1;
				2'd1: pop <= 1'($urandom_range(0, 1));
				2'd2: pop <= (stall_step[1:0] == 2'd0);
				default: pop <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Check each popped result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && pop && empty === 1'b0) begin
			results_seen++;
			if (traffic_due.size() == 0) begin
				mismatches++;
				$display("%0t ns: result with nothing expected, got %h", $time, result);
			end else begin
				oldest = traffic_due.pop_front();
				compare_field("kind", oldest.kind, result.kind);
				compare_field("out_key", oldest.out_key, result.out_key);
				compare_field("has_payload", oldest.has_payload, result.has_payload);
				compare_field("payload_word", oldest.payload_word, result.payload_word);
				compare_field("delta_value", oldest.delta_value, result.delta_value);
				compare_field("last_of_run", oldest.last_of_run, result.last_of_run);
				if (oldest.kind == 1'b0)
					packets_seen++;
				if (oldest.last_of_run)
					recordings_seen++;
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && full === 1'b0) || (pop && empty === 1'b0))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t ns: no request or result moved for %0d cycles",
					$time, QUIET_LIMIT);
				$display("network_traffic_generator_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		bit                writing;
		int                counted;
		int                r;
		logic [31:0]       rw;
		logic [31:0]       cv;
		logic [31:0]       per;
		logic [31:0]       prob;
		ntg_pkg::in_item_t c;

		// Directed table: reset values, extremes, send decision, bursting, runs
		directed_rows.push_back(row_typed(
			mk_cmd(ntg_pkg::OP_TICK, 32'h0, 1'b1, 4'd0, 32'h0), packet_of(32'h0, 1'b0)));
		directed_rows.push_back(row_req(mk_cmd(ntg_pkg::OP_TICK, 32'h0, 1'b0, 4'd0, 32'h0)));
		directed_rows.push_back(row_req(mk_cmd(ntg_pkg::OP_ARRIVED, 32'h0, 1'b0, 4'd0,
			32'h0)));
		directed_rows.push_back(row_req(mk_cmd(ntg_pkg::OP_CNT_UPDATE, 32'h0, 1'b0, 4'd0,
			ntg_pkg::ALL_ONES)));
		directed_rows.push_back(row_req(mk_cmd(ntg_pkg::OP_CNT_UPDATE, 32'h0, 1'b0, 4'd15,
			32'h1234_5678)));
		// empty recording: nothing selected yet
		directed_rows.push_back(row_req(mk_cmd(ntg_pkg::OP_END_RUN, 32'h0, 1'b0, 4'd0,
			32'h0)));
		directed_rows.push_back(row_write(ntg_pkg::REG_RECORD_MASK, ntg_pkg::ALL_ONES));
		directed_rows.push_back(row_write(ntg_pkg::REG_PACKET_KEY, ntg_pkg::ALL_ONES));
		directed_rows.push_back(row_write(ntg_pkg::REG_PAYLOAD_ENABLE, 32'h1));
		directed_rows.push_back(row_req(mk_cmd(ntg_pkg::OP_START_RUN, 32'h0, 1'b0, 4'd0,
			32'h0)));
		// router counter wraps from all ones to 5
		directed_rows.push_back(row_req(mk_cmd(ntg_pkg::OP_CNT_UPDATE, 32'h0, 1'b0, 4'd0,
			32'd5)));
		directed_rows.push_back(row_typed(
			mk_cmd(ntg_pkg::OP_TICK, ntg_pkg::ALL_ONES, 1'b1, 4'd0, 32'h0),
			packet_of(ntg_pkg::ALL_ONES, 1'b1)));
		directed_rows.push_back(row_req(mk_cmd(ntg_pkg::OP_END_RUN, 32'h0, 1'b0, 4'd0,
			32'h0)));
		directed_rows.push_back(row_req(mk_cmd(OP_SPARE_FIRST, ntg_pkg::ALL_ONES, 1'b1,
			4'd15, ntg_pkg::ALL_ONES)));
		directed_rows.push_back(row_req(mk_cmd(OP_SPARE_LAST, ntg_pkg::ALL_ONES, 1'b1,
			4'd15, ntg_pkg::ALL_ONES)));
		directed_rows.push_back(row_write(ntg_pkg::REG_SEND_PROBABILITY, 32'h0));
		directed_rows.push_back(row_write(ntg_pkg::REG_RECORD_INTERVAL, 32'h1));
		directed_rows.push_back(row_write(ntg_pkg::REG_RECORD_MASK, 32'h0103_0001));
		directed_rows.push_back(row_write(ntg_pkg::REG_PACKET_KEY, 32'hA5A5_0000));
		directed_rows.push_back(row_write(ntg_pkg::REG_PAYLOAD_ENABLE, 32'h0));
		directed_rows.push_back(row_req(mk_cmd(ntg_pkg::OP_TICK, 32'h0, 1'b1, 4'd0, 32'h0)));
		directed_rows.push_back(row_write(ntg_pkg::REG_SEND_PROBABILITY, 32'h8000_0000));
		directed_rows.push_back(row_req(mk_cmd(ntg_pkg::OP_TICK, 32'h7FFF_FFFF, 1'b1, 4'd0,
			32'h0)));
		directed_rows.push_back(row_req(mk_cmd(ntg_pkg::OP_TICK, 32'h8000_0000, 1'b1, 4'd0,
			32'h0)));
		directed_rows.push_back(row_write(ntg_pkg::REG_SEND_PROBABILITY, ntg_pkg::ALL_ONES));
		directed_rows.push_back(row_write(ntg_pkg::REG_BURST_PERIOD, 32'd3));
		directed_rows.push_back(row_write(ntg_pkg::REG_BURST_DUTY, 32'd1));
		directed_rows.push_back(row_write(ntg_pkg::REG_BURST_PHASE_START, 32'd0));
		directed_rows.push_back(row_write(ntg_pkg::REG_RECORD_INTERVAL, 32'd2));
		for (int i = 0; i < 4; i++)
			directed_rows.push_back(row_req(mk_cmd(ntg_pkg::OP_TICK, $urandom, i[0], 4'd0,
				32'h0)));
		// phase wraps at an all-ones period; interval write drops bit 31
		directed_rows.push_back(row_write(ntg_pkg::REG_BURST_PERIOD, ntg_pkg::ALL_ONES));
		directed_rows.push_back(row_write(ntg_pkg::REG_BURST_DUTY, ntg_pkg::ALL_ONES));
		directed_rows.push_back(row_write(ntg_pkg::REG_BURST_PHASE_START, 32'hFFFF_FFFE));
		directed_rows.push_back(row_write(ntg_pkg::REG_RECORD_INTERVAL, ntg_pkg::ALL_ONES));
		directed_rows.push_back(row_write(ntg_pkg::REG_RECORD_MASK, 32'h0));
		directed_rows.push_back(row_typed(
			mk_cmd(ntg_pkg::OP_TICK, 32'h0, 1'b1, 4'd0, 32'h0),
			packet_of(32'hA5A5_0000, 1'b0)));
		directed_rows.push_back(row_req(mk_cmd(ntg_pkg::OP_TICK, 32'h0, 1'b1, 4'd0, 32'h0)));
		directed_rows.push_back(row_req(mk_cmd(ntg_pkg::OP_START_RUN, 32'h0, 1'b0, 4'd0,
			32'h0)));
		directed_rows.push_back(row_req(mk_cmd(ntg_pkg::OP_END_RUN, 32'h0, 1'b0, 4'd0,
			32'h0)));
		directed_rows.push_back(row_write(ntg_pkg::REG_BURST_DUTY, 32'h0));
		directed_rows.push_back(row_req(mk_cmd(ntg_pkg::OP_TICK, 32'h0, 1'b1, 4'd0, 32'h0)));

		// Reset once
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		writing = 1'b0;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				if (!writing) begin
					wait_drained(IDLE_SETTLE);
					writing = 1'b1;
				end
				write_reg(directed_rows[i].sel, directed_rows[i].data);
			end else begin
				writing = 1'b0;
				send_request(directed_rows[i].cmd, directed_rows[i].kind == ROW_TYPED,
					directed_rows[i].typed);
			end
		end

		// Random runs, each under a fresh register setting
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_drained(IDLE_SETTLE);
			case (p)
				0: begin
					// every counter selected, recording on every tick
					write_reg(ntg_pkg::REG_RECORD_MASK, ntg_pkg::ALL_ONES);
					write_reg(ntg_pkg::REG_RECORD_INTERVAL, 32'd1);
					write_reg(ntg_pkg::REG_SEND_PROBABILITY, ntg_pkg::ALL_ONES);
					write_reg(ntg_pkg::REG_BURST_PERIOD, 32'h0);
					write_reg(ntg_pkg::REG_BURST_DUTY, 32'h0);
					write_reg(ntg_pkg::REG_BURST_PHASE_START, 32'h0);
					write_reg(ntg_pkg::REG_PACKET_KEY, $urandom);
					write_reg(ntg_pkg::REG_PAYLOAD_ENABLE, 32'h1);
				end
				1: begin
					write_reg(ntg_pkg::REG_RECORD_MASK, $urandom);
					write_reg(ntg_pkg::REG_RECORD_INTERVAL, 32'd2);
					write_reg(ntg_pkg::REG_SEND_PROBABILITY, 32'h0);
					write_reg(ntg_pkg::REG_BURST_PERIOD, ntg_pkg::ALL_ONES);
					write_reg(ntg_pkg::REG_BURST_DUTY, ntg_pkg::ALL_ONES);
					write_reg(ntg_pkg::REG_BURST_PHASE_START, ntg_pkg::ALL_ONES);
					write_reg(ntg_pkg::REG_PACKET_KEY, ntg_pkg::ALL_ONES);
					write_reg(ntg_pkg::REG_PAYLOAD_ENABLE, 32'hFFFF_FFFE);
				end
				default: begin
					per = $urandom_range(0, 8);
					case ($urandom_range(0, 3))
						0: prob = ntg_pkg::ALL_ONES;
						1: prob = 32'h4000_0000;
						2: prob = 32'hC000_0000;
						default: prob = $urandom;
					endcase
					write_reg(ntg_pkg::REG_RECORD_MASK,
						($urandom_range(0, 4) == 0) ? 32'h0 : $urandom);
					write_reg(ntg_pkg::REG_RECORD_INTERVAL, $urandom_range(0, 5));
					write_reg(ntg_pkg::REG_SEND_PROBABILITY, prob);
					write_reg(ntg_pkg::REG_BURST_PERIOD, per);
					write_reg(ntg_pkg::REG_BURST_DUTY, $urandom_range(0, per + 1));
					write_reg(ntg_pkg::REG_BURST_PHASE_START,
						(per != 0) ? $urandom_range(0, per - 1) : $urandom);
					write_reg(ntg_pkg::REG_PACKET_KEY, $urandom);
					write_reg(ntg_pkg::REG_PAYLOAD_ENABLE, $urandom);
				end
			endcase

			counted = 0;
			while (counted < PHASE_ITEMS) begin
				r  = $urandom_range(0, 99);
				case ($urandom_range(0, 3))
					0: rw = send_prob;
					1: rw = send_prob - 1;
					default: rw = $urandom;
				endcase
				case ($urandom_range(0, 5))
					0: cv = 32'h0;
					1: cv = ntg_pkg::ALL_ONES;
					default: cv = $urandom;
				endcase
				if (counted == 0)
					c = mk_cmd(ntg_pkg::OP_START_RUN, rw, 1'($urandom), 4'($urandom), cv);
				else if (counted == PHASE_ITEMS - 1)
					c = mk_cmd(ntg_pkg::OP_END_RUN, rw, 1'($urandom), 4'($urandom), cv);
				else if (r < 4)
					c = mk_cmd(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), rw,
						1'($urandom), 4'($urandom), cv);
				else if (r < 7)
					c = mk_cmd(ntg_pkg::OP_START_RUN, rw, 1'($urandom), 4'($urandom), cv);
				else if (r < 12)
					c = mk_cmd(ntg_pkg::OP_END_RUN, rw, 1'($urandom), 4'($urandom), cv);
				else if (r < 27)
					c = mk_cmd(ntg_pkg::OP_CNT_UPDATE, rw, 1'($urandom), 4'($urandom), cv);
				else if (r < 37)
					c = mk_cmd(ntg_pkg::OP_ARRIVED, rw, 1'($urandom), 4'($urandom), cv);
				else
					c = mk_cmd(ntg_pkg::OP_TICK, rw, $urandom_range(0, 3) != 0,
						4'($urandom), cv);
				send_request(c, 1'b0, '0);
				if (c.opcode < OP_SPARE_FIRST)
					counted++;
				// pause now and then until every result has come
				if ($urandom_range(0, 39) == 0)
					wait_drained(0);
			end
		end

		wait_drained(IDLE_SETTLE);

		$display("Covered %0d requests plus %0d spare opcodes and %0d register writes.",
			requests_sent, spare_ops, reg_writes);
		$display("Checked %0d results: %0d packets, %0d recordings, %0d mismatches.",
			results_seen, packets_seen, recordings_seen, mismatches);
		if (mismatches == 0 && traffic_due.size() == 0) begin
			$display("network_traffic_generator_core verification clean");
		end else begin
			if (traffic_due.size() != 0)
				$display("%0t ns: %0d expected results never arrived", $time,
					traffic_due.size());
			$display("network_traffic_generator_core verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
